// ===== rtl/positional_sequence_store_top_defines.svh =====
// ----------------------------------------------------------------------------
// positional_sequence_store_top_defines
// Assertion macros shared by the checker of the sequence store.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_TOP_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define PSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss check failed: next-cycle implication");

`endif

// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Types and codes shared by the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

    // fixed field widths of the request and response words
    localparam int KIND_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 5;

    // operation codes; the eighth code is a no-op
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_POP_BACK   = 3'd1,
        KIND_PUSH_FRONT = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_INSERT     = 3'd4,
        KIND_ERASE      = 3'd5,
        KIND_CLEAR      = 3'd6
    } kind_t;

    // request word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  item_value;
    } req_word_t;

    // response word
    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        logic             done_res;
        logic [CNT_W-1:0] entry_count;
    } rsp_word_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic open_gap;
        logic close_gap;
    } cell_op_t;

endpackage

// ===== rtl/positional_sequence_store_top.sv =====
// ----------------------------------------------------------------------------
// positional_sequence_store_top
// Bounded ordered list with push/pop at both ends, indexed insert and erase, and clear.
// ----------------------------------------------------------------------------
// One request word is taken per cycle while the output register is empty or
// is being read, and its response word appears in the output register on
// the next cycle. The values live in a row of CAPACITY cells; an insert or
// erase moves every cell above the position by one slot in that same cycle.
// Stored values are DATA_WIDTH bits wide: wider input values are truncated,
// and results are zero-extended or truncated to the 32-bit result field.
// The count field wraps modulo 32 for capacities above 31. No clearing pass
// is needed after reset.
module positional_sequence_store_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pss_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pss_pkg::rsp_word_t rsp
);
    import pss_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]         occupancy_reg;
    logic [CW-1:0]         occupancy_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_word_t             rsp_reg;
    logic                  accept;
    cell_op_t              op;
    cell_op_t              op_gated;
    logic [AW-1:0]         at;
    logic                  done;
    logic [DATA_WIDTH-1:0] fill;
    logic [DATA_WIDTH-1:0] removed;
    logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_taken [CAPACITY];

    // handshake
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    pss_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .req            (req),
        .occupancy      (occupancy_reg),
        .op             (op),
        .at             (at),
        .done           (done),
        .occupancy_next (occupancy_next)
    );

    assign op_gated = accept ? op : '0;
    assign fill     = DATA_WIDTH'(req.item_value);

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (g == 0)
        begin : g_first
            assign left = cell_data[g];
        end
        else
        begin : g_mid_lo
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right = cell_data[g];
        end
        else
        begin : g_mid_hi
            assign right = cell_data[g+1];
        end

        pss_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .AW         (AW),
            .IDX        (g)
        ) u_cell (
            .clk   (clk),
            .op    (op_gated),
            .at    (at),
            .fill  (fill),
            .left  (left),
            .right (right),
            .data  (cell_data[g]),
            .taken (cell_taken[g])
        );
    end

    // gather the erased value; at most one cell drives nonzero
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed = removed | cell_taken[i];
        end
    end

    // output valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                occupancy_reg <= occupancy_next;
            end
        end
    end

    // response word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.result_value <= VAL_W'(removed);
            rsp_reg.done_res     <= done;
            rsp_reg.entry_count  <= CNT_W'(occupancy_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/pss_cell.sv =====
// ----------------------------------------------------------------------------
// pss_cell
// One storage slot of the chain: holds, loads, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module pss_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  pss_pkg::cell_op_t     op,
    input  logic [AW-1:0]         at,
    input  logic [DATA_WIDTH-1:0] fill,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] taken
);
    import pss_pkg::*;

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = (at == MY_IDX);
    assign above = (MY_IDX > at);

    // shift up on open, shift down on close, load at the gap
    always_comb
    begin
        data_next = data_reg;
        if (op.open_gap && above)
        begin
            data_next = left;
        end
        else if (op.open_gap && hit)
        begin
            data_next = fill;
        end
        else if (op.close_gap && (above || hit))
        begin
            data_next = right;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    // value leaving the chain when this slot is erased
    assign taken = (op.close_gap && hit) ? data_reg : '0;

endmodule

// ===== rtl/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pss_ctrl
// Decodes an operation against the count into a shift command for the chain.
// ----------------------------------------------------------------------------
module pss_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  pss_pkg::req_word_t req,
    input  logic [CW-1:0]      occupancy,
    output pss_pkg::cell_op_t  op,
    output logic [AW-1:0]      at,
    output logic               done,
    output logic [CW-1:0]      occupancy_next
);
    import pss_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic            full;
    logic            empty;
    logic [CMPW-1:0] pos_c;
    logic [CMPW-1:0] occ_c;

    assign full  = (occupancy == CW'(CAPACITY));
    assign empty = (occupancy == '0);
    assign pos_c = CMPW'(req.position);
    assign occ_c = CMPW'(occupancy);

    // operation decode
    always_comb
    begin
        op   = '0;
        at   = '0;
        done = 1'b0;
        unique case (kind_t'(req.kind))
            KIND_PUSH_BACK:
            begin
                op.open_gap = !full;
                at          = AW'(occupancy);
            end
            KIND_POP_BACK:
            begin
                op.close_gap = !empty;
                at           = AW'(occupancy - CW'(1));
            end
            KIND_PUSH_FRONT:
            begin
                op.open_gap = !full;
            end
            KIND_POP_FRONT:
            begin
                op.close_gap = !empty;
            end
            KIND_INSERT:
            begin
                op.open_gap = !full && (pos_c <= occ_c);
                at          = AW'(pos_c);
            end
            KIND_ERASE:
            begin
                op.close_gap = (pos_c < occ_c);
                at           = AW'(pos_c);
            end
            KIND_CLEAR:
            begin
                done = !empty;
            end
            default:
            begin
                op = '0;
            end
        endcase
        if (op.open_gap || op.close_gap)
        begin
            done = 1'b1;
        end
    end

    // count after the operation
    always_comb
    begin
        occupancy_next = occupancy;
        if (kind_t'(req.kind) == KIND_CLEAR)
        begin
            occupancy_next = '0;
        end
        else if (op.open_gap)
        begin
            occupancy_next = occupancy + CW'(1);
        end
        else if (op.close_gap)
        begin
            occupancy_next = occupancy - CW'(1);
        end
    end

endmodule

// ===== rtl/pss_checker.sv =====
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks on the sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_sequence_store_top_defines.svh"

module pss_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input pss_pkg::req_word_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input pss_pkg::rsp_word_t rsp
);
    import pss_pkg::*;

    // a stalled response word holds
    `PSS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // every accepted word yields a response on the next cycle
    `PSS_ASSERT_NEXT(a_rsp_follows, clk, rst_n, req_valid && req_ready, rsp_valid)

    // the block never stalls with an empty output register
    `PSS_ASSERT_NOW(a_ready_idle, clk, rst_n, !rsp_valid, req_ready)

    // clear leaves the store empty
    `PSS_ASSERT_NEXT(a_clear_empty, clk, rst_n, req_valid && req_ready && (req.kind == KIND_CLEAR), rsp.entry_count == '0)

    // a failed operation returns no value
    `PSS_ASSERT_NOW(a_fail_zero, clk, rst_n, rsp_valid && !rsp.done_res, rsp.result_value == '0)

endmodule

bind positional_sequence_store_top pss_checker u_pss_checker (.*);
